@@ sv/ddalpg_pkg.sv @@
// ----------------------------------------------------------------------------
// ddalpg_pkg : shared types for the integer dda line pixel generator
// request and pixel payloads, action and step codes, coordinate stepping
// ----------------------------------------------------------------------------
package ddalpg_pkg;

    localparam int COORD_BITS = 10;
    localparam int ACC_BITS   = COORD_BITS + 1;
    localparam int COLOR_BITS = 16;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [ACC_BITS-1:0]   t_acc;
    typedef logic [COLOR_BITS-1:0] t_color;

    // request action
    typedef enum logic [0:0] {
        ACT_START = 1'b0,
        ACT_TICK  = 1'b1
    } t_action;

    // per-axis step code
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_INC  = 2'd1,
        STEP_DEC  = 2'd3
    } t_step;

    typedef struct packed {
        t_action action;
        t_coord  x_start;
        t_coord  y_start;
        t_coord  x_end;
        t_coord  y_end;
        t_color  color;
    } t_line_req;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        t_color pixel_color;
        logic   last_pixel;
    } t_pixel;

    // move one coordinate by its step code, wrapping at the coordinate width
    function automatic t_coord apply_step(input t_coord v, input t_step code);
        t_coord res;
        res = v;
        unique case (code)
            STEP_INC: res = v + t_coord'(1);
            STEP_DEC: res = v - t_coord'(1);
            default:  res = v;
        endcase
        return res;
    endfunction

endpackage

@@ sv/ddalpg_core.sv @@
// ----------------------------------------------------------------------------
// ddalpg_core : line state and combinational dda step
// latches a line on a start request and forms one pixel per tick request
// ----------------------------------------------------------------------------
module ddalpg_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  ddalpg_pkg::t_line_req i_req,
    output logic                 o_pix_valid,
    output ddalpg_pkg::t_pixel   o_pix
);
    import ddalpg_pkg::*;

    logic   r_busy, n_busy;
    logic   r_axis, n_axis;
    t_coord r_cur_x, n_cur_x;
    t_coord r_cur_y, n_cur_y;
    t_step  r_step_x, n_step_x;
    t_step  r_step_y, n_step_y;
    t_coord r_span_x, n_span_x;
    t_coord r_span_y, n_span_y;
    t_coord r_major, n_major;
    t_acc   r_acc_x, n_acc_x;
    t_acc   r_acc_y, n_acc_y;
    t_acc   r_left, n_left;
    t_color r_color, n_color;

    t_coord start_sx, start_sy;
    t_acc   sum_x, sum_y, major_w;
    logic   last;

    // endpoint spans for a start request
    assign start_sx = (i_req.x_start > i_req.x_end) ? i_req.x_start - i_req.x_end
                                                     : i_req.x_end - i_req.x_start;
    assign start_sy = (i_req.y_start > i_req.y_end) ? i_req.y_start - i_req.y_end
                                                     : i_req.y_end - i_req.y_start;

    // error accumulator sums for a tick
    assign major_w = {1'b0, r_major};
    assign sum_x   = r_acc_x + {1'b0, r_span_x};
    assign sum_y   = r_acc_y + {1'b0, r_span_y};
    assign last    = (r_left <= t_acc'(1));

    // pixel formed from the current position
    assign o_pix_valid       = i_take && (i_req.action == ACT_TICK) && r_busy;
    assign o_pix.pixel_x     = r_cur_x;
    assign o_pix.pixel_y     = r_cur_y;
    assign o_pix.pixel_color = r_color;
    assign o_pix.last_pixel  = last;

    // next line state
    always_comb begin
        n_busy   = r_busy;
        n_axis   = r_axis;
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_step_x = r_step_x;
        n_step_y = r_step_y;
        n_span_x = r_span_x;
        n_span_y = r_span_y;
        n_major  = r_major;
        n_acc_x  = r_acc_x;
        n_acc_y  = r_acc_y;
        n_left   = r_left;
        n_color  = r_color;
        if (i_take && (i_req.action == ACT_START)) begin
            n_busy   = 1'b1;
            n_color  = i_req.color;
            n_span_x = start_sx;
            n_span_y = start_sy;
            n_acc_x  = '0;
            n_acc_y  = '0;
            priority if (i_req.x_start == i_req.x_end) begin
                // vertical or single point, upward from the lower row
                n_axis   = 1'b1;
                n_cur_x  = i_req.x_start;
                n_cur_y  = (i_req.y_start < i_req.y_end) ? i_req.y_start : i_req.y_end;
                n_step_x = STEP_NONE;
                n_step_y = STEP_INC;
                n_major  = start_sy;
                n_left   = {1'b0, start_sy} + t_acc'(1);
            end else if (i_req.y_start == i_req.y_end) begin
                // horizontal, rightward from the lower column
                n_axis   = 1'b1;
                n_cur_x  = (i_req.x_start < i_req.x_end) ? i_req.x_start : i_req.x_end;
                n_cur_y  = i_req.y_start;
                n_step_x = STEP_INC;
                n_step_y = STEP_NONE;
                n_major  = start_sx;
                n_left   = {1'b0, start_sx} + t_acc'(1);
            end else begin
                // general line, first pixel is emitted twice
                n_axis   = 1'b0;
                n_cur_x  = i_req.x_start;
                n_cur_y  = i_req.y_start;
                n_step_x = (i_req.x_end > i_req.x_start) ? STEP_INC : STEP_DEC;
                n_step_y = (i_req.y_end > i_req.y_start) ? STEP_INC : STEP_DEC;
                n_major  = (start_sx > start_sy) ? start_sx : start_sy;
                n_left   = {1'b0, ((start_sx > start_sy) ? start_sx : start_sy)}
                           + t_acc'(2);
            end
        end else if (o_pix_valid) begin
            if (r_axis) begin
                n_cur_x = apply_step(r_cur_x, r_step_x);
                n_cur_y = apply_step(r_cur_y, r_step_y);
            end else begin
                n_acc_x = sum_x;
                n_acc_y = sum_y;
                if (sum_x > major_w) begin
                    n_acc_x = sum_x - major_w;
                    n_cur_x = apply_step(r_cur_x, r_step_x);
                end
                if (sum_y > major_w) begin
                    n_acc_y = sum_y - major_w;
                    n_cur_y = apply_step(r_cur_y, r_step_y);
                end
            end
            if (last) begin
                n_left = '0;
                n_busy = 1'b0;
            end else begin
                n_left = r_left - t_acc'(1);
            end
        end
    end

    // busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    // line datapath registers
    always_ff @(posedge i_clk) begin
        r_axis   <= n_axis;
        r_cur_x  <= n_cur_x;
        r_cur_y  <= n_cur_y;
        r_step_x <= n_step_x;
        r_step_y <= n_step_y;
        r_span_x <= n_span_x;
        r_span_y <= n_span_y;
        r_major  <= n_major;
        r_acc_x  <= n_acc_x;
        r_acc_y  <= n_acc_y;
        r_left   <= n_left;
        r_color  <= n_color;
    end

endmodule

@@ sv/integer_dda_line_pixel_generator_unit.sv @@
// ----------------------------------------------------------------------------
// integer_dda_line_pixel_generator_unit : line rasteriser, one pixel per tick
//
//   channel   direction   handshake                   payload
//   in        request     i_in_valid / o_in_stall     i_in_req  (t_line_req)
//   out       pixel       o_out_valid / i_out_stall   o_out_pix (t_pixel)
//
// a tick's pixel is formed by the dda step and appears in the output
// register on the following cycle; a request can be taken every cycle
// unless the input stalls. the dda step is combinational between line state
// and output register. reset clears the busy flag and the output valid.
// the input stalls only while a pixel sits in the output register and the
// output side stalls it.
// ----------------------------------------------------------------------------
module integer_dda_line_pixel_generator_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ddalpg_pkg::t_line_req i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ddalpg_pkg::t_pixel    o_out_pix
);
    import ddalpg_pkg::*;

    logic   take;
    logic   pix_valid;
    t_pixel pix;
    logic   r_out_valid, n_out_valid;
    t_pixel r_out_pix;

    // request taken while the output register can absorb a result
    assign o_in_stall = r_out_valid && i_out_stall;
    assign take       = i_in_valid && !o_in_stall;

    ddalpg_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_req       (i_in_req),
        .o_pix_valid (pix_valid),
        .o_pix       (pix)
    );

    // output valid tracking
    always_comb begin
        n_out_valid = r_out_valid;
        if (pix_valid) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (pix_valid) begin
            r_out_pix <= pix;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pix   = r_out_pix;

endmodule

@@ sv/ddalpg_checker.sv @@
// ----------------------------------------------------------------------------
// ddalpg_checker : port-level checks for the line pixel generator
// watches the request and pixel channels over time
// ----------------------------------------------------------------------------
module ddalpg_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input ddalpg_pkg::t_line_req i_in_req,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input ddalpg_pkg::t_pixel    o_out_pix
);
    import ddalpg_pkg::*;

    // a stalled pixel stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_pix))
        else $error("stalled pixel changed or vanished");

    // no pixel straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("pixel valid after reset");

    // input stalls only behind a stalled pixel
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked pixel");

    // a start request emits no pixel
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_req.action == ACT_START) |=> !o_out_valid)
        else $error("pixel emitted for a start request");

endmodule

bind integer_dda_line_pixel_generator_unit ddalpg_checker u_ddalpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_pix   (o_out_pix)
);

@@ test/ddalpg_pixel_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ddalpg_pixel_checker : pixel prediction and comparison for the line unit
// watches the request and pixel channels, steps its own line rasteriser on
// every accepted request and checks each accepted pixel against the oldest
// pixel still awaited; counts failures and pixels for the top level
// ----------------------------------------------------------------------------
module ddalpg_pixel_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  ddalpg_pkg::t_line_req i_in_req,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  ddalpg_pkg::t_pixel    i_out_pix,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_pixel_count
);

    import ddalpg_pkg::*;

    // predicted line state
    logic   drawing;
    logic   straight;
    t_coord pen_x;
    t_coord pen_y;
    t_step  dir_x;
    t_step  dir_y;
    t_coord run_x;
    t_coord run_y;
    t_coord long_run;
    t_acc   err_x;
    t_acc   err_y;
    t_acc   pixels_to_go;
    t_color ink;

    t_pixel expected_pixels[$];
    t_pixel awaited;
    int     failures = 0;
    int     pixels_seen = 0;

    // one unit move along an axis, wrapping at the coordinate width
    function automatic t_coord nudge(input t_coord v, input t_step dir);
        if (dir == STEP_INC) begin
            nudge = v + t_coord'(1);
        end else if (dir == STEP_DEC) begin
            nudge = v + {COORD_BITS{1'b1}};
        end else begin
            nudge = v;
        end
    endfunction

    // report one field mismatch, returns 1 when the field differs
    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // advance the line state by one request, queueing any pixel it emits
    task automatic rasterise_request(input t_line_req req);
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
        t_pixel pix;
        logic   final_pix;
        x0 = req.x_start;
        y0 = req.y_start;
        x1 = req.x_end;
        y1 = req.y_end;
        if (req.action == ACT_START) begin
            ink     = req.color;
            run_x   = (x0 > x1) ? x0 - x1 : x1 - x0;
            run_y   = (y0 > y1) ? y0 - y1 : y1 - y0;
            err_x   = '0;
            err_y   = '0;
            drawing = 1'b1;
            if (x0 == x1) begin
                // vertical, a single point included
                straight     = 1'b1;
                pen_x        = x0;
                pen_y        = (y0 < y1) ? y0 : y1;
                dir_x        = STEP_NONE;
                dir_y        = STEP_INC;
                long_run     = run_y;
                pixels_to_go = t_acc'(run_y) + t_acc'(1);
            end else if (y0 == y1) begin
                // horizontal
                straight     = 1'b1;
                pen_x        = (x0 < x1) ? x0 : x1;
                pen_y        = y0;
                dir_x        = STEP_INC;
                dir_y        = STEP_NONE;
                long_run     = run_x;
                pixels_to_go = t_acc'(run_x) + t_acc'(1);
            end else begin
                // sloped, first pixel comes out twice
                straight     = 1'b0;
                pen_x        = x0;
                pen_y        = y0;
                dir_x        = (x1 > x0) ? STEP_INC : STEP_DEC;
                dir_y        = (y1 > y0) ? STEP_INC : STEP_DEC;
                long_run     = (run_x > run_y) ? run_x : run_y;
                pixels_to_go = t_acc'(long_run) + t_acc'(2);
            end
        end else if (drawing) begin
            final_pix       = (pixels_to_go <= t_acc'(1));
            pix.pixel_x     = pen_x;
            pix.pixel_y     = pen_y;
            pix.pixel_color = ink;
            pix.last_pixel  = final_pix;
            expected_pixels.push_back(pix);
            if (straight) begin
                pen_x = nudge(pen_x, dir_x);
                pen_y = nudge(pen_y, dir_y);
            end else begin
                err_x = err_x + t_acc'(run_x);
                err_y = err_y + t_acc'(run_y);
                if (err_x > t_acc'(long_run)) begin
                    err_x = err_x - t_acc'(long_run);
                    pen_x = nudge(pen_x, dir_x);
                end
                if (err_y > t_acc'(long_run)) begin
                    err_y = err_y - t_acc'(long_run);
                    pen_y = nudge(pen_y, dir_y);
                end
            end
            if (final_pix) begin
                pixels_to_go = '0;
                drawing      = 1'b0;
            end else begin
                pixels_to_go = pixels_to_go - t_acc'(1);
            end
        end
    endtask

    // sample both channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drawing      = 1'b0;
            straight     = 1'b0;
            pen_x        = '0;
            pen_y        = '0;
            dir_x        = STEP_NONE;
            dir_y        = STEP_NONE;
            run_x        = '0;
            run_y        = '0;
            long_run     = '0;
            err_x        = '0;
            err_y        = '0;
            pixels_to_go = '0;
            ink          = '0;
            expected_pixels.delete();
        end else begin
            // pixels first: a pixel never belongs to a request taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                pixels_seen++;
                if (expected_pixels.size() == 0) begin
                    $error("pixel (%0d, %0d) emitted with none awaited",
                           i_out_pix.pixel_x, i_out_pix.pixel_y);
                    failures++;
                end else begin
                    awaited = expected_pixels.pop_front();
                    failures += field_differs("pixel_x", 32'(awaited.pixel_x),
                                              32'(i_out_pix.pixel_x));
                    failures += field_differs("pixel_y", 32'(awaited.pixel_y),
                                              32'(i_out_pix.pixel_y));
                    failures += field_differs("pixel_color", 32'(awaited.pixel_color),
                                              32'(i_out_pix.pixel_color));
                    failures += field_differs("last_pixel", 32'(awaited.last_pixel),
                                              32'(i_out_pix.last_pixel));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                rasterise_request(i_in_req);
            end
        end
        o_fail_count  <= failures;
        o_pending     <= expected_pixels.size();
        o_pixel_count <= pixels_seen;
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench : regression for the integer dda line pixel generator unit
// drives directed and random line requests with random gaps and output
// stalls, including a long output hold-off and drain pauses; the checker
// beside the block predicts every pixel and counts mismatches
// ----------------------------------------------------------------------------
module testbench;

    import ddalpg_pkg::*;

    localparam int ITEM_TARGET = 1100;
    localparam int STALL_LIMIT = 2000;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_line_req in_req = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_pixel    out_pix;

    int fail_count;
    int pending;
    int pixel_count;
    int items_sent = 0;
    int lines_started = 0;
    bit mid_pause_done = 1'b0;

    integer_dda_line_pixel_generator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_pix   (out_pix)
    );

    ddalpg_pixel_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_req      (in_req),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_pix     (out_pix),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_pixel_count (pixel_count)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hand one request over, with random gaps outside the quiet stretch
    task automatic offer(input t_line_req req);
        if (!(items_sent >= 600 && items_sent < 850)) begin
            while ($urandom_range(99) < 8) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic offer_start(input int x0, input int y0, input int x1, input int y1,
                               input t_color color);
        t_line_req req;
        req.action  = ACT_START;
        req.x_start = t_coord'(x0);
        req.y_start = t_coord'(y0);
        req.x_end   = t_coord'(x1);
        req.y_end   = t_coord'(y1);
        req.color   = color;
        lines_started++;
        offer(req);
    endtask

    // tick with random payload, which the block ignores
    task automatic offer_tick();
        t_line_req req;
        req.action  = ACT_TICK;
        req.x_start = t_coord'($urandom_range(COORD_MAX));
        req.y_start = t_coord'($urandom_range(COORD_MAX));
        req.x_end   = t_coord'($urandom_range(COORD_MAX));
        req.y_end   = t_coord'($urandom_range(COORD_MAX));
        req.color   = t_color'($urandom);
        offer(req);
    endtask

    // stop sending until every awaited pixel has arrived
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // coordinate within reach of v, kept on the panel
    function automatic int coord_near(input int v, input int reach);
        int d;
        int w;
        d = $urandom_range(2 * reach) - reach;
        w = v + d;
        if (w < 0 || w > COORD_MAX) begin
            w = v - d;
        end
        return w;
    endfunction

    // number of pixels a line gives
    function automatic int line_length(input int x0, input int y0, input int x1,
                                       input int y1);
        int dx;
        int dy;
        dx = (x0 > x1) ? x0 - x1 : x1 - x0;
        dy = (y0 > y1) ? y0 - y1 : y1 - y0;
        if (x0 == x1) begin
            return dy + 1;
        end
        if (y0 == y1) begin
            return dx + 1;
        end
        return ((dx > dy) ? dx : dy) + 2;
    endfunction

    // one random line: mostly short and run to the end, some cut short by a restart
    task automatic run_random_line();
        int kind;
        int reach;
        int x0;
        int y0;
        int x1;
        int y1;
        int len;
        int ticks;
        bit long_line;
        kind      = $urandom_range(99);
        reach     = (kind < 5) ? 100 : 15;
        long_line = (kind >= 19 && kind < 23);
        x0        = $urandom_range(COORD_MAX);
        y0        = $urandom_range(COORD_MAX);
        x1        = coord_near(x0, reach);
        y1        = coord_near(y0, reach);
        if (kind >= 5 && kind < 12) begin
            x1 = x0;
        end else if (kind >= 12 && kind < 19) begin
            y1 = y0;
        end else if (long_line) begin
            x1 = $urandom_range(COORD_MAX);
            y1 = $urandom_range(COORD_MAX);
        end
        len = line_length(x0, y0, x1, y1);
        if (long_line) begin
            ticks = $urandom_range(40);
        end else if ($urandom_range(99) < 15) begin
            ticks = $urandom_range(len - 1);
        end else begin
            ticks = len;
        end
        if (ticks > len) begin
            ticks = len;
        end
        offer_start(x0, y0, x1, y1, t_color'($urandom));
        items_sent++;
        repeat (ticks) begin
            offer_tick();
            items_sent++;
        end
        // occasional tick after the line has finished
        if (ticks == len && $urandom_range(99) < 10) begin
            offer_tick();
        end
    endtask

    // request source and verdict
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle tick, corner to corner cut short, point, reversed axes,
        // sloped line stepping down on both axes
        offer_tick();
        offer_start(0, 0, COORD_MAX, COORD_MAX, 16'hFFFF);
        repeat (3) offer_tick();
        offer_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'h0000);
        repeat (2) offer_tick();
        offer_start(COORD_MAX, 0, COORD_MAX - 3, 0, 16'hAAAA);
        repeat (4) offer_tick();
        offer_start(0, COORD_MAX, 0, COORD_MAX - 2, 16'h5555);
        repeat (3) offer_tick();
        offer_start(5, 5, 2, 3, 16'h1234);
        repeat (5) offer_tick();
        drain();

        // random lines, with one pause midway until the pixels are all out
        while (items_sent < ITEM_TARGET) begin
            run_random_line();
            if (!mid_pause_done && items_sent >= ITEM_TARGET / 2) begin
                drain();
                mid_pause_done = 1'b1;
            end
        end
        drain();
        repeat (10) @(posedge clk);

        $display("run covered %0d line starts and %0d counted requests, %0d pixels checked",
                 lines_started, items_sent, pixel_count);
        $display("including reversed, axis aligned, single point and restarted lines");
        if (fail_count == 0) begin
            $display("integer_dda_line_pixel_generator_unit regression: pass");
        end else begin
            $display("integer_dda_line_pixel_generator_unit regression: fail");
        end
        $finish;
    end

    // pixel sink: random stalls, a long hold-off, then a stretch with none
    initial begin
        int rx_cycle;
        rx_cycle = 0;
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle >= 400 && rx_cycle < 650) begin
                out_stall <= 1'b1;
            end else if (rx_cycle >= 900 && rx_cycle < 1200) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < 8);
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("integer_dda_line_pixel_generator_unit regression: fail");
        $finish;
    end

endmodule

@@ integer_dda_line_pixel_generator_unit.f @@
sv/ddalpg_pkg.sv
sv/ddalpg_core.sv
sv/integer_dda_line_pixel_generator_unit.sv
sv/ddalpg_checker.sv
test/ddalpg_pixel_checker.sv
test/testbench.sv
